// ===== hdl/sjis_printer_kanji_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the kanji encoder RTL.
// ----------------------------------------------------------------------------
`ifndef SJIS_PRINTER_KANJI_ENCODER_DEFINES_SVH
`define SJIS_PRINTER_KANJI_ENCODER_DEFINES_SVH

// Checked on every rising edge while reset is released.
`define SJPK_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SJPK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/sjpk_pkg.sv =====
// ----------------------------------------------------------------------------
// sjpk_pkg
// Types, escape tables and helpers shared by the kanji encoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sjpk_pkg;

	localparam int QUEUE_DEPTH = 4;

	// Printer models 0 up to this one use the first escape family.
	localparam logic [2:0] MODEL_FAMILY_A_LAST = 3'd2;
	// This model uses the second escape family; higher models send none.
	localparam logic [2:0] MODEL_FAMILY_B      = 3'd3;

	// Which escape sequence precedes the data bytes of a job.
	typedef enum logic [2:0] {
		ESC_NONE  = 3'd0,
		ESC_IN_A  = 3'd1,
		ESC_OUT_A = 3'd2,
		ESC_IN_B  = 3'd3,
		ESC_OUT_B = 3'd4
	} esc_t;

	// One unit of output work handed from the front to the back.
	typedef struct packed {
		esc_t       esc;
		logic       pair;   // two data bytes (JIS pair) instead of one
		logic [7:0] data0;  // plain byte, or JIS high byte
		logic [7:0] data1;  // JIS low byte
	} job_t;

	localparam logic [7:0] ESC_IN_A_SEQ [8] =
		'{8'h1C, 8'h42, 8'h1B, 8'h4B, 8'h00, 8'h00, 8'h00, 8'h00};
	localparam logic [7:0] ESC_OUT_A_SEQ [8] =
		'{8'h1B, 8'h48, 8'h1C, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00};
	localparam logic [7:0] ESC_IN_B_SEQ [8] =
		'{8'h1C, 8'h26, 8'h1C, 8'h53, 8'h03, 8'h09, 8'h00, 8'h00};
	localparam logic [7:0] ESC_OUT_B_SEQ [8] =
		'{8'h1C, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

	function automatic logic is_lead(input logic [7:0] b);
		return (b inside {[8'h81:8'h9F], [8'hE0:8'hFC]});
	endfunction

	function automatic logic [3:0] esc_len(input esc_t e);
		logic [3:0] n;
		case (e)
			ESC_IN_A:  n = 4'd4;
			ESC_OUT_A: n = 4'd4;
			ESC_IN_B:  n = 4'd6;
			ESC_OUT_B: n = 4'd2;
			default:   n = 4'd0;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] esc_byte(input esc_t e, input logic [2:0] idx);
		logic [7:0] b;
		case (e)
			ESC_IN_A:  b = ESC_IN_A_SEQ[idx];
			ESC_OUT_A: b = ESC_OUT_A_SEQ[idx];
			ESC_IN_B:  b = ESC_IN_B_SEQ[idx];
			ESC_OUT_B: b = ESC_OUT_B_SEQ[idx];
			default:   b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/sjpk_front.sv =====
// ----------------------------------------------------------------------------
// sjpk_front
// Accepts text bytes, pairs lead and trail bytes, tracks the printer mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sjis_printer_kanji_encoder_defines.svh"

module sjpk_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [2:0]     cfg_data,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire logic [7:0]     s_tdata,
	input  wire logic           full,
	output logic                push,
	output sjpk_pkg::job_t      job
);
	import sjpk_pkg::*;

	logic       lead_q;
	logic [7:0] lead_val_q;
	logic       kanji_q;
	logic [2:0] model_q;

	logic       accept;
	logic [7:0] b;
	logic [7:0] hi_base, hi_odd, hi, lo_m, lo;
	logic       lo_wrap;
	logic       to_kanji;
	esc_t       esc;

	assign cfg_ready = 1'b1;
	assign s_tready  = !full;
	assign accept    = s_tvalid && s_tready;
	assign b         = s_tdata;

	// Shift-JIS to JIS arithmetic, every byte wrapping modulo 256.
	always_comb begin
		hi_base = lead_val_q - ((lead_val_q <= 8'h9F) ? 8'h71 : 8'hB1);
		hi_odd  = {hi_base[6:0], 1'b1};
		lo_m    = b - {7'd0, (b > 8'h7F)};
		lo_wrap = (lo_m >= 8'h9E);
		hi      = hi_odd + {7'd0, lo_wrap};
		lo      = lo_wrap ? (lo_m - 8'h7D) : (lo_m - 8'h1F);
	end

	assign to_kanji = lead_q;

	always_comb begin
		esc = ESC_NONE;
		if (kanji_q != to_kanji) begin
			if (model_q <= MODEL_FAMILY_A_LAST) begin
				esc = to_kanji ? ESC_IN_A : ESC_OUT_A;
			end else if (model_q == MODEL_FAMILY_B) begin
				esc = to_kanji ? ESC_IN_B : ESC_OUT_B;
			end
		end
	end

	assign push      = accept && (lead_q || !is_lead(b));
	assign job.esc   = esc;
	assign job.pair  = lead_q;
	assign job.data0 = lead_q ? hi : b;
	assign job.data1 = lo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q     <= 1'b0;
			lead_val_q <= 8'h00;
			kanji_q    <= 1'b0;
			model_q    <= 3'd0;
		end else begin
			if (cfg_valid) begin
				model_q <= cfg_data;
			end
			if (accept) begin
				if (lead_q) begin
					lead_q     <= 1'b0;
					lead_val_q <= 8'h00;
				end else if (is_lead(b)) begin
					lead_q     <= 1'b1;
					lead_val_q <= b;
				end
			end
			if (push) begin
				kanji_q <= to_kanji;
			end
		end
	end

	`SJPK_ASSERT(a_pair_sets_kanji, clk, arst_n, push && job.pair |=> kanji_q, "pair did not leave kanji mode set")
	`SJPK_ASSERT(a_no_push_full, clk, arst_n, !(push && full), "job pushed into a full queue")

endmodule

`default_nettype wire

// ===== hdl/sjpk_queue.sv =====
// ----------------------------------------------------------------------------
// sjpk_queue
// Small register queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sjis_printer_kanji_encoder_defines.svh"

module sjpk_queue #(
	parameter int DEPTH = sjpk_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire sjpk_pkg::job_t wr_job,
	output logic                full,
	input  wire logic           pop,
	output logic                rd_valid,
	output sjpk_pkg::job_t      rd_job
);
	import sjpk_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

	job_t          entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full     = (count_q == DEPTH_C);
	assign rd_valid = (count_q != '0);
	assign rd_job   = entry_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`SJPK_ASSERT(a_count_bound, clk, arst_n, count_q <= DEPTH_C, "queue fill count above depth")

endmodule

`default_nettype wire

// ===== hdl/sjpk_back.sv =====
// ----------------------------------------------------------------------------
// sjpk_back
// Expands one job into escape and data bytes, one byte per cycle unless the output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sjis_printer_kanji_encoder_defines.svh"

module sjpk_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire sjpk_pkg::job_t q_job,
	output logic                pop,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	output logic [7:0]          m_tdata,
	output logic                m_tlast
);
	import sjpk_pkg::*;

	job_t       cur_q;
	logic       cur_v_q;
	logic [2:0] idx_q;
	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic       m_tlast_q;

	logic [3:0] elen, len, idx_w;
	logic       last, load;
	logic [7:0] byte_sel;

	assign elen  = esc_len(cur_q.esc);
	assign len   = elen + (cur_q.pair ? 4'd2 : 4'd1);
	assign idx_w = {1'b0, idx_q};
	assign last  = (idx_w == len - 4'd1);

	always_comb begin
		if (idx_w < elen) begin
			byte_sel = esc_byte(cur_q.esc, idx_q);
		end else if (idx_w == elen) begin
			byte_sel = cur_q.data0;
		end else begin
			byte_sel = cur_q.data1;
		end
	end

	assign load = cur_v_q && (!m_tvalid_q || m_tready);
	assign pop  = q_valid && (!cur_v_q || (load && last));

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_job;
		end
		if (load) begin
			m_tdata_q <= byte_sel;
			m_tlast_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q    <= 1'b0;
			idx_q      <= 3'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (pop) begin
				cur_v_q <= 1'b1;
				idx_q   <= 3'd0;
			end else if (load && last) begin
				cur_v_q <= 1'b0;
			end else if (load) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	`SJPK_ASSERT(a_drain_empty, clk, arst_n, m_tvalid && m_tready && !cur_v_q && !q_valid |=> !m_tvalid, "output stayed valid with no work left")

endmodule

`default_nettype wire

// ===== hdl/sjis_printer_kanji_encoder.sv =====
// ----------------------------------------------------------------------------
// sjis_printer_kanji_encoder
// Shift-JIS text bytes in, printer bytes (escapes, JIS pairs, plain) out.
// ----------------------------------------------------------------------------
// Usage:
// Text enters one byte per word on the s_ stream; printer bytes leave one
// per word on the m_ stream, with m_tlast marking the final byte caused by
// an input word. A lead byte produces nothing and is held until the next
// word, which is always taken as its trail and converted to a JIS pair.
// A mode change (into or out of kanji) first emits the escape sequence of
// the printer model chosen on the cfg_ channel; models above 3 send none.
// The first output byte of a word passes the queue, the back's job register
// and the output register after the word is accepted. The output side moves
// one byte per cycle while m_tready is high; a plain byte yields one output
// byte, a JIS pair two, a pair with an entry escape up to eight, a lead none.
// A four-entry job queue sits between the classifying front and the byte
// expanding back, so input keeps flowing while the back works off escapes.
// Reset clears the mode to single-byte, drops any held lead byte, sets the
// printer model to zero and empties the queue and output register.
// When the receiver stalls, the output word holds, the back stops, and once
// the queue fills s_tready drops until space frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sjis_printer_kanji_encoder_defines.svh"

module sjis_printer_kanji_encoder #(
	parameter int QDEPTH = sjpk_pkg::QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// Configuration: printer_model, written when cfg_valid and cfg_ready.
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [2:0] cfg_data,     // [2:0] printer_model
	// Text input stream.
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,      // [7:0] text_byte
	// Printer output stream.
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,      // [7:0] out_byte
	output logic            m_tlast       // last_of_run
);
	import sjpk_pkg::*;

	job_t push_job, pop_job;
	logic push, full, pop, q_valid;

	// Front: pairs lead/trail bytes, decides escapes, tracks kanji mode.
	sjpk_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.full      (full),
		.push      (push),
		.job       (push_job)
	);

	// Job queue decoupling the two sides.
	sjpk_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_job   (push_job),
		.full     (full),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_job   (pop_job)
	);

	// Back: serializes escape and data bytes into the output register.
	sjpk_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_job    (pop_job),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	`SJPK_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !m_tvalid, "output valid while in reset")

endmodule

`default_nettype wire
